// ===== sv/tgrg_pkg.sv =====
// ----------------------------------------------------------------------------
// tgrg_pkg
// shared types and constants of the tiled matrix-multiply request generator
// ----------------------------------------------------------------------------
package tgrg_pkg;

  localparam int unsigned BlockMDefault = 8;
  localparam int unsigned BlockNDefault = 8;
  localparam int unsigned BlockKDefault = 4;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned DimW    = 16;
  localparam int unsigned EbW     = 5;
  localparam int unsigned BytesW  = 11;
  localparam int unsigned InnerW  = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MulW    = 2 * DimW;
  localparam int unsigned OffW    = 18;

  localparam logic [AddrW-1:0] ABaseReset      = 64'd0;
  localparam logic [AddrW-1:0] BBaseReset      = 64'd8192;
  localparam logic [AddrW-1:0] CBaseReset      = 64'd16384;
  localparam logic [DimW-1:0]  RowStartReset   = 16'd0;
  localparam logic [DimW-1:0]  RowEndReset     = 16'd64;
  localparam logic [DimW-1:0]  ColCountReset   = 16'd64;
  localparam logic [DimW-1:0]  DepthCountReset = 16'd32;
  localparam logic [EbW-1:0]   ElemBytesReset  = 5'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgABase      = 3'd0,
    CfgBBase      = 3'd1,
    CfgCBase      = 3'd2,
    CfgRowStart   = 3'd3,
    CfgRowEnd     = 3'd4,
    CfgColCount   = 3'd5,
    CfgDepthCount = 3'd6,
    CfgElemBytes  = 3'd7
  } tgrg_cfg_idx_e;

  typedef enum logic [1:0] {
    PhReadA  = 2'd0,
    PhReadB  = 2'd1,
    PhWriteC = 2'd2
  } tgrg_phase_e;

  typedef struct packed {
    logic [AddrW-1:0] a_base;
    logic [AddrW-1:0] b_base;
    logic [AddrW-1:0] c_base;
    logic [DimW-1:0]  row_start;
    logic [DimW-1:0]  row_end;
    logic [DimW-1:0]  col_count;
    logic [DimW-1:0]  depth_count;
    logic [EbW-1:0]   element_bytes;
  } tgrg_cfg_t;

  typedef struct packed {
    tgrg_phase_e       phase;
    logic [DimW-1:0]   tile_row;
    logic [DimW-1:0]   tile_col;
    logic [DimW-1:0]   tile_depth;
    logic [InnerW-1:0] inner_row;
    logic [InnerW-1:0] inner_col;
    logic              last;
  } tgrg_req_t;

endpackage

// ===== sv/tiled_gemm_request_generator.sv =====
// ----------------------------------------------------------------------------
// tiled_gemm_request_generator
// memory request generator for a tiled matrix-multiply traffic pattern
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i/in_ready_o, restart_i): each transaction asks
//   for the next request; restart_i high rewinds to the start of a pass first.
//   a transaction yields one request, or none once the pass is finished or
//   the pass is empty.
//   output channel (out_valid_o/out_ready_i): address, length, write flag and
//   an end-of-pass flag.
//   config port (cfg_we_i, cfg_idx_i, cfg_data_i): written while idle.
//   path: a request goes from its input transaction through the queue write,
//   then the multiply stage, then the base add into the output register.
//   throughput: one transaction per cycle while the receiver does not stall;
//   every pipeline stage then takes a new transaction each cycle.
//   reset: config takes its default values, counters rewind, queue empties.
//   receiver stall: the output register and multiply stage hold, the 2-entry
//   queue fills, then in_ready_o drops.
// ----------------------------------------------------------------------------
module tiled_gemm_request_generator #(
  parameter int unsigned BlockM = tgrg_pkg::BlockMDefault,
  parameter int unsigned BlockN = tgrg_pkg::BlockNDefault,
  parameter int unsigned BlockK = tgrg_pkg::BlockKDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tgrg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tgrg_pkg::AddrW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tgrg_pkg::AddrW-1:0]    request_address_o,
  output logic [tgrg_pkg::BytesW-1:0]   request_bytes_o,
  output logic                          is_write_o,
  output logic                          last_of_pass_o
);

  tgrg_pkg::tgrg_cfg_t cfg_q;
  tgrg_pkg::tgrg_req_t push_req, pop_req;
  logic                push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_base        <= tgrg_pkg::ABaseReset;
      cfg_q.b_base        <= tgrg_pkg::BBaseReset;
      cfg_q.c_base        <= tgrg_pkg::CBaseReset;
      cfg_q.row_start     <= tgrg_pkg::RowStartReset;
      cfg_q.row_end       <= tgrg_pkg::RowEndReset;
      cfg_q.col_count     <= tgrg_pkg::ColCountReset;
      cfg_q.depth_count   <= tgrg_pkg::DepthCountReset;
      cfg_q.element_bytes <= tgrg_pkg::ElemBytesReset;
    end else if (cfg_we_i) begin
      unique case (tgrg_pkg::tgrg_cfg_idx_e'(cfg_idx_i))
        tgrg_pkg::CfgABase:      cfg_q.a_base        <= cfg_data_i;
        tgrg_pkg::CfgBBase:      cfg_q.b_base        <= cfg_data_i;
        tgrg_pkg::CfgCBase:      cfg_q.c_base        <= cfg_data_i;
        tgrg_pkg::CfgRowStart:   cfg_q.row_start     <= cfg_data_i[tgrg_pkg::DimW-1:0];
        tgrg_pkg::CfgRowEnd:     cfg_q.row_end       <= cfg_data_i[tgrg_pkg::DimW-1:0];
        tgrg_pkg::CfgColCount:   cfg_q.col_count     <= cfg_data_i[tgrg_pkg::DimW-1:0];
        tgrg_pkg::CfgDepthCount: cfg_q.depth_count   <= cfg_data_i[tgrg_pkg::DimW-1:0];
        tgrg_pkg::CfgElemBytes:  cfg_q.element_bytes <= cfg_data_i[tgrg_pkg::EbW-1:0];
        default:                 cfg_q               <= cfg_q;
      endcase
    end
  end

  tgrg_front #(
    .BlockM (BlockM),
    .BlockN (BlockN),
    .BlockK (BlockK)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .full_i     (full),
    .push_o     (push),
    .req_o      (push_req)
  );

  tgrg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_req),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_req)
  );

  tgrg_back #(
    .BlockM (BlockM),
    .BlockN (BlockN),
    .BlockK (BlockK)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .empty_i           (empty),
    .pop_o             (pop),
    .req_i             (pop_req),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .request_address_o (request_address_o),
    .request_bytes_o   (request_bytes_o),
    .is_write_o        (is_write_o),
    .last_of_pass_o    (last_of_pass_o)
  );

endmodule

// ===== sv/tgrg_front.sv =====
// ----------------------------------------------------------------------------
// tgrg_front
// loop counters: takes restart/advance items and emits request descriptors
// ----------------------------------------------------------------------------
module tgrg_front #(
  parameter int unsigned BlockM = tgrg_pkg::BlockMDefault,
  parameter int unsigned BlockN = tgrg_pkg::BlockNDefault,
  parameter int unsigned BlockK = tgrg_pkg::BlockKDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tgrg_pkg::tgrg_cfg_t cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  input  logic                full_i,
  output logic                push_o,
  output tgrg_pkg::tgrg_req_t req_o
);

  localparam int unsigned IrW  = (BlockM > 1) ? $clog2(BlockM) : 1;
  localparam int unsigned IcW  = (BlockN > 1) ? $clog2(BlockN) : 1;
  localparam int unsigned CmpW = tgrg_pkg::DimW + 1;

  logic [tgrg_pkg::DimW-1:0] row_q, row_d, col_q, col_d, dep_q, dep_d;
  logic [IrW-1:0]            ir_q, ir_d;
  logic [IcW-1:0]            ic_q, ic_d;
  tgrg_pkg::tgrg_phase_e     ph_q, ph_d;
  logic                      done_q, done_d;

  logic [tgrg_pkg::DimW-1:0] e_row, e_col, e_dep;
  logic [IrW-1:0]            e_ir;
  logic [IcW-1:0]            e_ic;
  tgrg_pkg::tgrg_phase_e     e_ph;
  logic                      e_done;
  logic                      fire, empty_pass, last;
  logic [CmpW-1:0]           next_dep, next_col, next_row;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    if (restart_i) begin
      e_row  = cfg_i.row_start;
      e_col  = '0;
      e_dep  = '0;
      e_ir   = '0;
      e_ic   = '0;
      e_ph   = tgrg_pkg::PhReadA;
      e_done = 1'b0;
    end else begin
      e_row  = row_q;
      e_col  = col_q;
      e_dep  = dep_q;
      e_ir   = ir_q;
      e_ic   = ic_q;
      e_ph   = ph_q;
      e_done = done_q;
    end
  end

  assign empty_pass = (e_row >= cfg_i.row_end) || (cfg_i.col_count == '0) ||
                      (cfg_i.depth_count == '0);
  assign next_dep = CmpW'(e_dep) + CmpW'(BlockK);
  assign next_col = CmpW'(e_col) + CmpW'(BlockN);
  assign next_row = CmpW'(e_row) + CmpW'(BlockM);

  // advance through phase, inner column, inner row, depth, column, row tiles
  always_comb begin
    row_d = e_row;
    col_d = e_col;
    dep_d = e_dep;
    ir_d  = e_ir;
    ic_d  = e_ic;
    ph_d  = e_ph;
    last  = 1'b0;
    priority if (e_ph != tgrg_pkg::PhWriteC) begin
      ph_d = (e_ph == tgrg_pkg::PhReadA) ? tgrg_pkg::PhReadB : tgrg_pkg::PhWriteC;
    end else if (e_ic != IcW'(BlockN - 1)) begin
      ph_d = tgrg_pkg::PhReadA;
      ic_d = e_ic + IcW'(1);
    end else if (e_ir != IrW'(BlockM - 1)) begin
      ph_d = tgrg_pkg::PhReadA;
      ic_d = '0;
      ir_d = e_ir + IrW'(1);
    end else if (next_dep < CmpW'(cfg_i.depth_count)) begin
      ph_d  = tgrg_pkg::PhReadA;
      ic_d  = '0;
      ir_d  = '0;
      dep_d = next_dep[tgrg_pkg::DimW-1:0];
    end else if (next_col < CmpW'(cfg_i.col_count)) begin
      ph_d  = tgrg_pkg::PhReadA;
      ic_d  = '0;
      ir_d  = '0;
      dep_d = '0;
      col_d = next_col[tgrg_pkg::DimW-1:0];
    end else if (next_row < CmpW'(cfg_i.row_end)) begin
      ph_d  = tgrg_pkg::PhReadA;
      ic_d  = '0;
      ir_d  = '0;
      dep_d = '0;
      col_d = '0;
      row_d = next_row[tgrg_pkg::DimW-1:0];
    end else begin
      ph_d  = tgrg_pkg::PhReadA;
      ic_d  = '0;
      ir_d  = '0;
      dep_d = '0;
      col_d = '0;
      row_d = cfg_i.row_start;
      last  = 1'b1;
    end
  end

  always_comb begin
    done_d = e_done;
    if (!e_done) begin
      done_d = empty_pass ? 1'b1 : last;
    end
  end

  assign push_o = fire && !e_done && !empty_pass;

  always_comb begin
    req_o.phase      = e_ph;
    req_o.tile_row   = e_row;
    req_o.tile_col   = e_col;
    req_o.tile_depth = e_dep;
    req_o.inner_row  = tgrg_pkg::InnerW'(e_ir);
    req_o.inner_col  = tgrg_pkg::InnerW'(e_ic);
    req_o.last       = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= tgrg_pkg::RowStartReset;
      col_q  <= '0;
      dep_q  <= '0;
      ir_q   <= '0;
      ic_q   <= '0;
      ph_q   <= tgrg_pkg::PhReadA;
      done_q <= 1'b0;
    end else if (fire) begin
      done_q <= done_d;
      if (push_o) begin
        row_q <= row_d;
        col_q <= col_d;
        dep_q <= dep_d;
        ir_q  <= ir_d;
        ic_q  <= ic_d;
        ph_q  <= ph_d;
      end else begin
        row_q <= e_row;
        col_q <= e_col;
        dep_q <= e_dep;
        ir_q  <= e_ir;
        ic_q  <= e_ic;
        ph_q  <= e_ph;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !restart_i && done_q) |-> !push_o)
    else $error("request issued after end of pass");
`endif

endmodule

// ===== sv/tgrg_fifo.sv =====
// ----------------------------------------------------------------------------
// tgrg_fifo
// two-entry descriptor queue between the counter front and the address back
// ----------------------------------------------------------------------------
module tgrg_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tgrg_pkg::tgrg_req_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output tgrg_pkg::tgrg_req_t data_o
);

  tgrg_pkg::tgrg_req_t mem_q [2];
  logic                wr_q, rd_q;
  logic [1:0]          count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != 2'd0))
    else $error("pop from empty queue");
`endif

endmodule

// ===== sv/tgrg_back.sv =====
// ----------------------------------------------------------------------------
// tgrg_back
// address pipeline: multiply stage, then base add into the output register
// ----------------------------------------------------------------------------
module tgrg_back #(
  parameter int unsigned BlockM = tgrg_pkg::BlockMDefault,
  parameter int unsigned BlockN = tgrg_pkg::BlockNDefault,
  parameter int unsigned BlockK = tgrg_pkg::BlockKDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tgrg_pkg::tgrg_cfg_t           cfg_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  tgrg_pkg::tgrg_req_t           req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tgrg_pkg::AddrW-1:0]    request_address_o,
  output logic [tgrg_pkg::BytesW-1:0]   request_bytes_o,
  output logic                          is_write_o,
  output logic                          last_of_pass_o
);

  localparam int unsigned OffW = tgrg_pkg::OffW;
  localparam int unsigned MulW = tgrg_pkg::MulW;

  logic                          adv;
  logic [tgrg_pkg::DimW-1:0]     mul_a, mul_b;
  logic [OffW-1:0]               off_d;
  logic                          s1_valid_q;
  logic [MulW-1:0]               s1_mul_q;
  logic [OffW-1:0]               s1_off_q;
  tgrg_pkg::tgrg_phase_e         s1_ph_q;
  logic                          s1_last_q;
  logic [tgrg_pkg::AddrW-1:0]    base;
  logic [11:0]                   rd_bytes;
  logic [tgrg_pkg::BytesW-1:0]   bytes_d;

  assign adv   = !out_valid_o || out_ready_i;
  assign pop_o = adv && !empty_i;

  always_comb begin
    unique case (req_i.phase)
      tgrg_pkg::PhReadA: begin
        mul_a = req_i.tile_row;
        mul_b = cfg_i.depth_count;
        off_d = OffW'(req_i.tile_depth) + OffW'(req_i.inner_row) * OffW'(BlockK);
      end
      tgrg_pkg::PhReadB: begin
        mul_a = req_i.tile_col;
        mul_b = cfg_i.depth_count;
        off_d = OffW'(req_i.tile_depth) + OffW'(req_i.inner_col) * OffW'(BlockK);
      end
      tgrg_pkg::PhWriteC: begin
        mul_a = req_i.tile_row;
        mul_b = cfg_i.col_count;
        off_d = OffW'(req_i.tile_col) + OffW'(req_i.inner_row) * OffW'(BlockN)
              + OffW'(req_i.inner_col) * OffW'(BlockM);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        off_d = '0;
      end
    endcase
  end

  always_comb begin
    unique case (s1_ph_q)
      tgrg_pkg::PhReadA:  base = cfg_i.a_base;
      tgrg_pkg::PhReadB:  base = cfg_i.b_base;
      tgrg_pkg::PhWriteC: base = cfg_i.c_base;
      default:            base = '0;
    endcase
  end

  assign rd_bytes = 12'(BlockK) * 12'(cfg_i.element_bytes);
  assign bytes_d  = (s1_ph_q == tgrg_pkg::PhWriteC) ?
                    tgrg_pkg::BytesW'(cfg_i.element_bytes) :
                    rd_bytes[tgrg_pkg::BytesW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mul_q          <= MulW'(mul_a) * MulW'(mul_b);
      s1_off_q          <= off_d;
      s1_ph_q           <= req_i.phase;
      s1_last_q         <= req_i.last;
      request_address_o <= base + tgrg_pkg::AddrW'(s1_mul_q)
                         + tgrg_pkg::AddrW'(s1_off_q);
      request_bytes_o   <= bytes_d;
      is_write_o        <= (s1_ph_q == tgrg_pkg::PhWriteC);
      last_of_pass_o    <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= pop_o;
      out_valid_o <= s1_valid_q;
    end
  end

`ifndef SYNTHESIS
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && adv) |=> out_valid_o)
    else $error("address stage lost a transaction");
`endif

endmodule

// ===== verif/tb_tiled_gemm_request_generator.sv =====
// ----------------------------------------------------------------------------
// tb_tiled_gemm_request_generator
// self-checking testbench of the tiled matrix-multiply request generator
// ----------------------------------------------------------------------------
// clocked driver fed from a queue of restart flags, clocked monitor with its
// own copy of the tile loops, checks every request field by field
// directed part: reset values, wrapping addresses, zero and widest element
// widths, empty passes, row start moved in the middle of a pass
// random part: small loop shapes with sender and receiver idling in turn
// ----------------------------------------------------------------------------
module tb_tiled_gemm_request_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import tgrg_pkg::*;

  localparam int unsigned BlockM      = BlockMDefault;
  localparam int unsigned BlockN      = BlockNDefault;
  localparam int unsigned BlockK      = BlockKDefault;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned TargetItems = 1550;
  localparam int unsigned PassLen     = 3 * BlockM * BlockN;
  localparam int unsigned PrintLimit  = 200;

  typedef enum int unsigned {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct {
    logic [AddrW-1:0]  address;
    logic [BytesW-1:0] bytes;
    logic              is_write;
    logic              last;
  } gemm_request_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [AddrW-1:0]    cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [AddrW-1:0]    request_address_o;
  logic [BytesW-1:0]   request_bytes_o;
  logic                is_write_o;
  logic                last_of_pass_o;

  logic                pending_restarts[$];
  gemm_request_t       expected_requests[$];
  gemm_request_t       oldest_request;
  int unsigned         mismatch_count = 0;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;

  tgrg_cfg_t           model_cfg;
  logic [DimW-1:0]     walk_row;
  logic [DimW-1:0]     walk_col;
  logic [DimW-1:0]     walk_depth;
  logic [InnerW-1:0]   walk_inner_row;
  logic [InnerW-1:0]   walk_inner_col;
  tgrg_phase_e         walk_phase;
  logic                walk_done;

  tiled_gemm_request_generator DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .restart_i         (restart_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .request_address_o (request_address_o),
    .request_bytes_o   (request_bytes_o),
    .is_write_o        (is_write_o),
    .last_of_pass_o    (last_of_pass_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] got,
                                 input logic [AddrW-1:0] want);
    if (mismatch_count < PrintLimit) begin
      $display("ERROR at %0t ns: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic rewind_pass();
    walk_row       = model_cfg.row_start;
    walk_col       = '0;
    walk_depth     = '0;
    walk_inner_row = '0;
    walk_inner_col = '0;
    walk_phase     = PhReadA;
    walk_done      = 1'b0;
  endtask

  task automatic predict_request(input logic do_restart);
    gemm_request_t req;
    int unsigned   nxt;
    if (do_restart) rewind_pass();
    if (walk_done) return;
    if (walk_row >= model_cfg.row_end || model_cfg.col_count == '0 ||
        model_cfg.depth_count == '0) begin
      walk_done = 1'b1;
      return;
    end
    case (walk_phase)
      PhReadA: begin
        req.address = model_cfg.a_base
                    + AddrW'(walk_row) * AddrW'(model_cfg.depth_count)
                    + AddrW'(walk_depth) + AddrW'(walk_inner_row) * AddrW'(BlockK);
        req.bytes    = BytesW'(BlockK * model_cfg.element_bytes);
        req.is_write = 1'b0;
      end
      PhReadB: begin
        req.address = model_cfg.b_base
                    + AddrW'(walk_col) * AddrW'(model_cfg.depth_count)
                    + AddrW'(walk_depth) + AddrW'(walk_inner_col) * AddrW'(BlockK);
        req.bytes    = BytesW'(BlockK * model_cfg.element_bytes);
        req.is_write = 1'b0;
      end
      default: begin
        req.address = model_cfg.c_base
                    + AddrW'(walk_row) * AddrW'(model_cfg.col_count) + AddrW'(walk_col)
                    + AddrW'(walk_inner_row) * AddrW'(BlockN)
                    + AddrW'(walk_inner_col) * AddrW'(BlockM);
        req.bytes    = BytesW'(model_cfg.element_bytes);
        req.is_write = 1'b1;
      end
    endcase
    req.last = 1'b0;
    // loop bounds compared in 32 bits so a step past the 16-bit range ends the loop
    if (walk_phase != PhWriteC) begin
      walk_phase = tgrg_phase_e'(walk_phase + 2'd1);
    end else begin
      walk_phase = PhReadA;
      if (walk_inner_col + 1 < BlockN) begin
        walk_inner_col++;
      end else begin
        walk_inner_col = '0;
        if (walk_inner_row + 1 < BlockM) begin
          walk_inner_row++;
        end else begin
          walk_inner_row = '0;
          nxt = walk_depth + BlockK;
          if (nxt < model_cfg.depth_count) begin
            walk_depth = DimW'(nxt);
          end else begin
            walk_depth = '0;
            nxt = walk_col + BlockN;
            if (nxt < model_cfg.col_count) begin
              walk_col = DimW'(nxt);
            end else begin
              walk_col = '0;
              nxt = walk_row + BlockM;
              if (nxt < model_cfg.row_end) begin
                walk_row = DimW'(nxt);
              end else begin
                walk_row  = model_cfg.row_start;
                req.last  = 1'b1;
                walk_done = 1'b1;
              end
            end
          end
        end
      end
    end
    expected_requests.insert(expected_requests.size(), req);
  endtask

  // narrow registers get random upper data bits, which the block must drop
  task automatic write_reg(input tgrg_cfg_idx_e idx, input logic [AddrW-1:0] value);
    logic [AddrW-1:0] data;
    data = {$urandom, $urandom};
    case (idx)
      CfgABase:      begin data = value; model_cfg.a_base = value; end
      CfgBBase:      begin data = value; model_cfg.b_base = value; end
      CfgCBase:      begin data = value; model_cfg.c_base = value; end
      CfgRowStart:   begin data[DimW-1:0] = value[DimW-1:0]; model_cfg.row_start = value[DimW-1:0]; end
      CfgRowEnd:     begin data[DimW-1:0] = value[DimW-1:0]; model_cfg.row_end = value[DimW-1:0]; end
      CfgColCount:   begin data[DimW-1:0] = value[DimW-1:0]; model_cfg.col_count = value[DimW-1:0]; end
      CfgDepthCount: begin
        data[DimW-1:0] = value[DimW-1:0];
        model_cfg.depth_count = value[DimW-1:0];
      end
      default: begin
        data[EbW-1:0] = value[EbW-1:0];
        model_cfg.element_bytes = value[EbW-1:0];
      end
    endcase
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic run_phase(input int unsigned count, input bit lead_restart,
                           input bit restart_noise, input idle_mode_e idle_mode);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idle_mode)
      IdleNone:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IdleSender:   begin send_idle_pct = 58; recv_stall_pct = 0;  end
      IdleReceiver: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      default:      begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
    for (int unsigned n = 0; n < count; n++) begin
      pending_restarts.insert(pending_restarts.size(),
                              n == 0 ? lead_restart
                                     : (restart_noise && $urandom_range(399) == 0));
    end
    do @(negedge clk_i);
    while (pending_restarts.size() != 0 || in_valid_i || expected_requests.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_restarts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        restart_i  <= pending_restarts.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        restart_i  <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_requests.size() == 0) begin
          report_mismatch("request with no transaction pending, address", request_address_o, '0);
        end else begin
          oldest_request = expected_requests.pop_front();
          if (request_address_o !== oldest_request.address)
            report_mismatch("request_address", request_address_o, oldest_request.address);
          if (request_bytes_o !== oldest_request.bytes)
            report_mismatch("request_bytes", AddrW'(request_bytes_o), AddrW'(oldest_request.bytes));
          if (is_write_o !== oldest_request.is_write)
            report_mismatch("is_write", AddrW'(is_write_o), AddrW'(oldest_request.is_write));
          if (last_of_pass_o !== oldest_request.last)
            report_mismatch("last_of_pass", AddrW'(last_of_pass_o), AddrW'(oldest_request.last));
        end
      end
      if (in_valid_i && in_ready_o) predict_request(restart_i);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned row_first, row_bound, cols, depth, elem, row_tiles, pass_items, count;
    int unsigned phase_no, random_items;
    bit          lead, wide;
    logic [AddrW-1:0] base_a, base_b, base_c;

    model_cfg = '{a_base: ABaseReset, b_base: BBaseReset, c_base: CBaseReset,
                  row_start: RowStartReset, row_end: RowEndReset,
                  col_count: ColCountReset, depth_count: DepthCountReset,
                  element_bytes: ElemBytesReset};
    rewind_pass();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values
    run_phase(4, 1'b0, 1'b0, IdleNone);

    // wrapping addresses, largest products and widest element
    write_reg(CfgABase, '1);
    write_reg(CfgBBase, 64'hFFFF_FFFF_FFFF_FFF0);
    write_reg(CfgCBase, '1);
    write_reg(CfgRowStart, 64'd65528);
    write_reg(CfgRowEnd, 64'd65535);
    write_reg(CfgColCount, 64'd65535);
    write_reg(CfgDepthCount, 64'd65535);
    write_reg(CfgElemBytes, 64'd31);
    run_phase(6, 1'b1, 1'b0, IdleNone);

    // zero element width
    write_reg(CfgElemBytes, 64'd0);
    write_reg(CfgABase, 64'd0);
    run_phase(3, 1'b1, 1'b0, IdleBoth);

    // row start moved in the middle of a pass keeps the current row
    write_reg(CfgRowStart, 64'd16);
    write_reg(CfgRowEnd, 64'd40);
    write_reg(CfgColCount, 64'd16);
    write_reg(CfgDepthCount, 64'd8);
    write_reg(CfgElemBytes, 64'd16);
    run_phase(3, 1'b1, 1'b0, IdleNone);
    write_reg(CfgRowStart, 64'd0);
    run_phase(3, 1'b0, 1'b0, IdleNone);

    // empty passes
    write_reg(CfgColCount, 64'd0);
    run_phase(2, 1'b1, 1'b0, IdleNone);
    write_reg(CfgColCount, 64'd8);
    write_reg(CfgDepthCount, 64'd0);
    run_phase(2, 1'b1, 1'b0, IdleNone);
    write_reg(CfgDepthCount, 64'd4);
    write_reg(CfgRowStart, 64'd65535);
    write_reg(CfgRowEnd, 64'd65535);
    run_phase(2, 1'b1, 1'b0, IdleNone);

    phase_no     = 0;
    random_items = 0;
    while (random_items < TargetItems) begin
      wide = ($urandom_range(9) < 3);
      if ($urandom_range(9) == 0) begin
        base_a = '1 - AddrW'($urandom_range(4095));
        base_b = '1 - AddrW'($urandom_range(4095));
        base_c = '1 - AddrW'($urandom_range(4095));
      end else begin
        base_a = {$urandom, $urandom};
        base_b = {$urandom, $urandom};
        base_c = {$urandom, $urandom};
      end
      case ($urandom_range(19))
        0: begin
          row_first = 65528 + $urandom_range(7);
          row_bound = 65535;
        end
        1: begin
          row_first = $urandom_range(65535);
          row_bound = $urandom_range(row_first);
        end
        default: begin
          row_first = $urandom_range(200);
          row_bound = row_first + $urandom_range(wide ? 16 : 8, 1);
        end
      endcase
      cols  = ($urandom_range(19) == 0) ? 0 : $urandom_range(wide ? 16 : 8, 1);
      depth = ($urandom_range(19) == 0) ? 0 : $urandom_range(wide ? 8 : 4, 1);
      elem  = ($urandom_range(19) == 0) ? $urandom_range(31) : $urandom_range(16, 1);
      write_reg(CfgABase, base_a);
      write_reg(CfgBBase, base_b);
      write_reg(CfgCBase, base_c);
      write_reg(CfgRowStart, AddrW'(row_first));
      write_reg(CfgRowEnd, AddrW'(row_bound));
      write_reg(CfgColCount, AddrW'(cols));
      write_reg(CfgDepthCount, AddrW'(depth));
      write_reg(CfgElemBytes, AddrW'(elem));
      row_tiles  = (row_bound > row_first) ? (row_bound - row_first + BlockM - 1) / BlockM : 0;
      pass_items = row_tiles * ((cols + BlockN - 1) / BlockN) * ((depth + BlockK - 1) / BlockK)
                 * PassLen;
      lead = ($urandom_range(4) != 0);
      if (!lead) count = $urandom_range(200, 20);
      else if (pass_items == 0) count = $urandom_range(6, 1);
      else count = pass_items + $urandom_range(6);
      run_phase(count, lead, 1'b1, idle_mode_e'(phase_no % 4));
      if (lead) random_items += pass_items;
      phase_no++;
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
